// ===== hw/rtl/ssa_pkg.sv =====
package ssa_pkg;

  localparam int NUM_CHUNKS_DEF = 16;
  localparam int MAX_SLOTS_DEF  = 8;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_SHRINK = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFRM  = 2'd1,
    ST_BADFRE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TAG_UNUSED  = 2'd0,
    TAG_FREE    = 2'd1,
    TAG_PARTIAL = 2'd2,
    TAG_FULL    = 2'd3
  } tag_t;

  localparam logic [0:0] CFG_SLOTS = 1'b0;
  localparam logic [0:0] CFG_LIMIT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic shrink_step;
    logic finish;
  } ssa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_shrink;
    logic free_empty;
  } ssa_sts_t;

endpackage

// ===== hw/rtl/ssa_dp.sv =====
module ssa_dp
  import ssa_pkg::*;
#(
  parameter int NUM_CHUNKS = NUM_CHUNKS_DEF,
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ssa_cmd_t   cmd,
  output ssa_sts_t   sts,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_free_chunk,
  input  logic [2:0] in_free_slot,
  input  logic       cfg_wr,
  input  logic       cfg_idx,
  input  logic [4:0] cfg_data,
  output logic [1:0] out_status,
  output logic [3:0] out_alloc_chunk,
  output logic [2:0] out_alloc_slot,
  output logic [4:0] out_free_chunks,
  output logic [4:0] out_partial_chunks,
  output logic [4:0] out_full_chunks,
  output logic [4:0] out_released_chunks
);
  localparam int CW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int LW = $clog2(NUM_CHUNKS + 1);
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int MW = $clog2(MAX_SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_CHUNKS);

  // freshly grown stack: each slot links to the one below, slot 0 to itself
  function automatic logic [MAX_SLOTS*SW-1:0] link_init();
    logic [MAX_SLOTS*SW-1:0] v;
    v = '0;
    for (int i = 1; i < MAX_SLOTS; i++) v[i*SW +: SW] = SW'(i - 1);
    return v;
  endfunction

  localparam logic [MAX_SLOTS*SW-1:0] LINK_INIT = link_init();

  logic [3:0] spc_r;
  logic [4:0] afl_r;
  // one word per chunk holding its packed slot links
  logic [MAX_SLOTS*SW-1:0] link_r [NUM_CHUNKS];
  logic [SW-1:0] top_r [NUM_CHUNKS];
  logic [MW-1:0] fs_r [NUM_CHUNKS];
  logic [MW-1:0] mx_r [NUM_CHUNKS];
  tag_t          tag_r [NUM_CHUNKS];
  logic [LW-1:0] nx_r [NUM_CHUNKS];
  logic [LW-1:0] pv_r [NUM_CHUNKS];
  logic [LW-1:0] hd_r [3];
  logic [LW-1:0] cn_r [3];
  logic [1:0] icmd_r;
  logic [3:0] ich_r;
  logic [2:0] isl_r;
  logic [4:0] rel_r;

  assign sts.is_shrink  = (icmd_r == CMD_SHRINK);
  assign sts.free_empty = (hd_r[0] == NIL);

  logic [MW-1:0] eff;
  always_comb begin
    eff = MW'(spc_r);
    if (spc_r == 4'd0) eff = MW'(1);
    if (32'(spc_r) > MAX_SLOTS) eff = MW'(MAX_SLOTS);
  end

  logic          unu_found;
  logic [CW-1:0] unu_idx;
  always_comb begin
    unu_found = 1'b0;
    unu_idx   = '0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (tag_r[i] == TAG_UNUSED) begin
        unu_found = 1'b1;
        unu_idx   = CW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    // working copies for one item, list moves applied in sequence
    automatic logic [LW-1:0] nx [NUM_CHUNKS];
    automatic logic [LW-1:0] pv [NUM_CHUNKS];
    automatic tag_t          tg [NUM_CHUNKS];
    automatic logic [LW-1:0] hd [3];
    automatic logic [LW-1:0] cn [3];
    automatic logic [CW-1:0] c;
    automatic logic [SW-1:0] s;
    automatic logic          ok;
    automatic logic          from_free;
    automatic logic [MW-1:0] nf;
    automatic logic [1:0]    st;
    automatic logic [3:0]    ac;
    automatic logic [2:0]    as_;
    automatic logic [1:0]    t;
    automatic logic [LW-1:0] p;
    automatic logic [LW-1:0] n;
    nx = nx_r; pv = pv_r; tg = tag_r; hd = hd_r; cn = cn_r;
    c = '0; s = '0; ok = 1'b0; from_free = 1'b1; nf = '0;
    st = ST_OK; ac = '0; as_ = '0; t = '0; p = '0; n = '0;
    if (!rst_n) begin
      spc_r <= 4'd8;
      afl_r <= 5'd16;
      for (int i = 0; i < NUM_CHUNKS; i++) tag_r[i] <= TAG_UNUSED;
      tag_r[0] <= TAG_FREE;
      nx_r[0] <= NIL;
      pv_r[0] <= NIL;
      hd_r[0] <= '0;
      hd_r[1] <= NIL;
      hd_r[2] <= NIL;
      cn_r[0] <= LW'(1);
      cn_r[1] <= '0;
      cn_r[2] <= '0;
      link_r[0] <= LINK_INIT;
      top_r[0] <= SW'(MAX_SLOTS - 1);
      fs_r[0]  <= MW'(MAX_SLOTS);
      mx_r[0]  <= MW'(MAX_SLOTS);
      icmd_r <= CMD_NOP;
      rel_r  <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_idx == CFG_SLOTS) spc_r <= cfg_data[3:0];
        else afl_r <= cfg_data;
      end
      if (cmd.load) begin
        icmd_r <= in_cmd;
        ich_r  <= in_free_chunk;
        isl_r  <= in_free_slot;
        rel_r  <= '0;
      end
      if (cmd.shrink_step) begin
        c = CW'(hd_r[0]);
        n = nx_r[c];
        hd_r[0] <= n;
        if (n != NIL) pv_r[CW'(n)] <= NIL;
        cn_r[0] <= cn_r[0] - LW'(1);
        tag_r[c] <= TAG_UNUSED;
        rel_r <= rel_r + 5'd1;
      end
      if (cmd.exec) begin
        if (icmd_r == CMD_ALLOC) begin
          if (hd[1] != NIL) begin
            c = CW'(hd[1]); from_free = 1'b0; ok = 1'b1;
          end else if (hd[0] != NIL) begin
            c = CW'(hd[0]); ok = 1'b1;
          end else if (unu_found) begin
            c = unu_idx; ok = 1'b1;
            link_r[c] <= LINK_INIT;
            mx_r[c] <= eff;
            // grown then popped: fs = eff - 1
            nf = eff - MW'(1);
            // push onto free list
            nx[c] = hd[0]; pv[c] = NIL; hd[0] = LW'(c);
            cn[0] = cn[0] + LW'(1); tg[c] = TAG_FREE;
          end
          if (!ok) st = ST_NOFRM;
          else begin
            if (!(tg[c] == TAG_FREE && tag_r[c] == TAG_UNUSED)) begin
              nf = fs_r[c] - MW'(1);
              s = top_r[c];
            end else s = SW'(eff - MW'(1));
            ac = 4'(c); as_ = 3'(s);
            top_r[c] <= (tag_r[c] == TAG_UNUSED) ?
                        ((s == '0) ? '0 : SW'(s - SW'(1))) : link_r[c][SW*s +: SW];
            fs_r[c] <= nf;
            if (nf == '0 || from_free) begin
              t = 2'(tg[c]) - 2'd1; p = pv[c]; n = nx[c];
              if (p == NIL) hd[t] = n; else nx[CW'(p)] = n;
              if (n != NIL) pv[CW'(n)] = p;
              cn[t] = cn[t] - LW'(1);
              t = (nf == '0) ? 2'd2 : 2'd1;
              nx[c] = hd[t]; pv[c] = NIL;
              if (hd[t] != NIL) pv[CW'(hd[t])] = LW'(c);
              hd[t] = LW'(c); cn[t] = cn[t] + LW'(1);
              tg[c] = (nf == '0) ? TAG_FULL : TAG_PARTIAL;
            end
          end
        end else if (icmd_r == CMD_FREE) begin
          c = CW'(ich_r);
          s = SW'(isl_r);
          if (32'(ich_r) >= NUM_CHUNKS ||
              (tg[c] != TAG_PARTIAL && tg[c] != TAG_FULL) ||
              32'(isl_r) >= MAX_SLOTS || MW'(isl_r) >= mx_r[c]) begin
            st = ST_BADFRE;
          end else begin
            link_r[c][SW*s +: SW] <= top_r[c];
            top_r[c] <= s;
            nf = (fs_r[c] < mx_r[c]) ? fs_r[c] + MW'(1) : fs_r[c];
            fs_r[c] <= nf;
            if (nf == mx_r[c] || nf == MW'(1)) begin
              t = 2'(tg[c]) - 2'd1; p = pv[c]; n = nx[c];
              if (p == NIL) hd[t] = n; else nx[CW'(p)] = n;
              if (n != NIL) pv[CW'(n)] = p;
              cn[t] = cn[t] - LW'(1);
              tg[c] = TAG_UNUSED;
              if (nf == mx_r[c]) begin
                if (32'(cn[0]) <= 32'(afl_r)) begin
                  t = 2'd0; tg[c] = TAG_FREE;
                end else t = 2'd3;
              end else begin
                t = 2'd1; tg[c] = TAG_PARTIAL;
              end
              if (t != 2'd3) begin
                nx[c] = hd[t]; pv[c] = NIL;
                if (hd[t] != NIL) pv[CW'(hd[t])] = LW'(c);
                hd[t] = LW'(c); cn[t] = cn[t] + LW'(1);
              end
            end
          end
        end
        nx_r <= nx; pv_r <= pv; tag_r <= tg; hd_r <= hd; cn_r <= cn;
        out_status      <= st;
        out_alloc_chunk <= ac;
        out_alloc_slot  <= as_;
      end
      if (cmd.finish && icmd_r == CMD_SHRINK) begin
        out_status      <= ST_OK;
        out_alloc_chunk <= '0;
        out_alloc_slot  <= '0;
      end
    end
  end

  assign out_free_chunks     = 5'(cn_r[0]);
  assign out_partial_chunks  = 5'(cn_r[1]);
  assign out_full_chunks     = 5'(cn_r[2]);
  assign out_released_chunks = (icmd_r == CMD_SHRINK) ? rel_r : 5'd0;
endmodule

// ===== hw/rtl/ssa_ctrl.sv =====
module ssa_ctrl
  import ssa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ssa_cmd_t cmd,
  input  ssa_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SHRK  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_shrink) state_nxt = S_SHRK;
        else begin
          cmd.exec = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_SHRK: begin
        if (sts.free_empty) begin
          cmd.finish = 1'b1;
          state_nxt = S_OUT;
        end else cmd.shrink_step = 1'b1;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ===== hw/rtl/slab_slot_allocator.sv =====
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | cmd, free_chunk, free_slot
// out     | output    | out_valid/out_stall| status, alloc_chunk, alloc_slot, counts
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// alloc, free and no-op pass through accept, execute and result for each word;
// shrink also steps once per chunk on the free list (a list walk) before its result
// synchronous reset builds chunk 0 on the free list at once, no clearing pass
// a stalled result holds in the output register and blocks the next word
module slab_slot_allocator
  import ssa_pkg::*;
#(
  parameter int NUM_CHUNKS = NUM_CHUNKS_DEF,
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_free_chunk,
  input  logic [2:0] in_free_slot,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [3:0] out_alloc_chunk,
  output logic [2:0] out_alloc_slot,
  output logic [4:0] out_free_chunks,
  output logic [4:0] out_partial_chunks,
  output logic [4:0] out_full_chunks,
  output logic [4:0] out_released_chunks,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data
);
  ssa_cmd_t cmd;
  ssa_sts_t sts;

  assign cfg_ready = 1'b1;

  ssa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd, .sts
  );

  ssa_dp #(.NUM_CHUNKS(NUM_CHUNKS), .MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_cmd, .in_free_chunk, .in_free_slot,
    .cfg_wr(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .out_status, .out_alloc_chunk, .out_alloc_slot,
    .out_free_chunks, .out_partial_chunks, .out_full_chunks,
    .out_released_chunks
  );
endmodule
